// ----- rtl/shuffled_minimal_lcg_rng_defines.svh -----
// Assertion macros used by the top-level RTL file of the shuffled Lehmer generator.
`ifndef SHUFFLED_MINIMAL_LCG_RNG_DEFINES_SVH
`define SHUFFLED_MINIMAL_LCG_RNG_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define SLMR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition that must never be seen outside reset.
`define SLMR_ASSERT_NEVER(name, clk, rst_n, cond) \
  `SLMR_ASSERT(name, clk, rst_n, !(cond))
`else
`define SLMR_ASSERT(name, clk, rst_n, prop)
`define SLMR_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ----- rtl/slmr_pkg.sv -----
// Constants and shared types of the shuffled Lehmer generator.
package slmr_pkg;

  localparam int unsigned ValueW = 31;
  localparam int unsigned MulW = 15;
  localparam int unsigned ProdW = ValueW + MulW;

  localparam logic [ValueW-1:0] LehmerMod = 31'h7FFF_FFFF;
  localparam logic [MulW-1:0] LehmerMul = 15'd16807;

  localparam int unsigned WarmupExtra = 8;
  localparam int unsigned TableSizeDefault = 32;

  // Operation codes of an input item.
  localparam logic OpDraw = 1'b0;
  localparam logic OpSeed = 1'b1;

  // Request to the shared multiply and fold unit.
  typedef struct packed {
    logic              load;
    logic [ValueW-1:0] a;
    logic [MulW-1:0]   b;
  } mul_req_t;

endpackage

// ----- rtl/slmr_req_if.sv -----
// Request channel: operation code and seed of one item.
interface slmr_req_if
  import slmr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ValueW-1:0] seed;

  modport source (output valid, output operation, output seed, input ready);
  modport sink (input valid, input operation, input seed, output ready);
endinterface

// ----- rtl/slmr_rsp_if.sv -----
// Response channel: one random value per item.
interface slmr_rsp_if
  import slmr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

// ----- rtl/shuffled_minimal_lcg_rng.sv -----
// Top level of the shuffled minimal-standard Lehmer random number generator.
// This block is a Park-Miller generator, x = 16807 * x mod (2^31 - 1), whose
// outputs pass through a Bays-Durham shuffle table of TableSize entries. Each
// request item yields exactly one response item carrying a 31 bit integer in
// 1 .. 2^31-2; divide it by 2^31-1 for a uniform fraction. An item with
// operation OpSeed reseeds the generator from its seed field (zero and the
// modulus itself are treated as one), which runs TableSize + 8 warm-up steps
// that fill the table, and then draws. A plain draw issued before any seeding
// seeds itself from the stored generator state first. The request side takes
// a new item only while the sequencer is idle. A plain draw occupies the
// block from acceptance until the next item can be taken, for one state
// step on the shared multiplier, a second pass through the same multiplier
// to scale the last output into a table slot, and the registered read of
// the table memory. A seeding item runs its warm-up first, and every warm-up
// step needs a multiply state and a fold state on the shared unit.
// The response sits in an output register, so a new request is accepted
// while a finished value still waits; the following result is held back only
// until that value has been taken. There is no clearing pass after reset;
// the table is always written by a seeding before it is read.
`include "shuffled_minimal_lcg_rng_defines.svh"

module shuffled_minimal_lcg_rng
  import slmr_pkg::*;
#(
  parameter int unsigned TableSize = TableSizeDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slmr_req_if.sink  req_i,
  slmr_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned StepCnt = TableSize + WarmupExtra;
  localparam int unsigned CntW = $clog2(StepCnt);
  localparam logic [CntW-1:0] CntLast = CntW'(StepCnt - 1);
  localparam logic [CntW-1:0] CntTable = CntW'(TableSize);
  localparam logic [MulW-1:0] SizeMul = MulW'(TableSize);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(TableSize - 1);
  localparam logic [IdxW-1:0] SlotCorr = IdxW'(TableSize - 2);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SMUL  = 7'b0000010,
    S_SFOLD = 7'b0000100,
    S_DMUL  = 7'b0001000,
    S_DFOLD = 7'b0010000,
    S_SLOT  = 7'b0100000,
    S_READ  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0] lehmer_q, lehmer_d;
  logic [ValueW-1:0] last_q, last_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;

  mul_req_t          mul_req;
  logic [ProdW-1:0]  mul_prod;
  logic [ValueW-1:0] mul_mod;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic              ram_re;
  logic [ValueW-1:0] ram_rdata;

  logic              req_fire;
  logic              out_free;
  logic [ValueW-1:0] seed_in;
  logic [ValueW-1:0] seed_fixed;

  logic [IdxW-1:0]   slot_cand;
  logic [2*IdxW-1:0] slot_excess;
  logic [IdxW-1:0]   slot_raw;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // A seed of zero or of the modulus itself would lock the generator.
  assign seed_in    = (req_i.operation == OpSeed) ? req_i.seed : lehmer_q;
  assign seed_fixed = ((seed_in == '0) || (seed_in == LehmerMod)) ? ValueW'(1) : seed_in;

  // The shared unit steps the generator, and in the fold cycle of a draw it
  // scales the last output by the table size for the slot choice.
  always_comb begin
    mul_req.load = (state_q == S_SMUL) || (state_q == S_DMUL) || (state_q == S_DFOLD);
    mul_req.a    = (state_q == S_DFOLD) ? last_q : lehmer_q;
    mul_req.b    = (state_q == S_DFOLD) ? SizeMul : LehmerMul;
  end

  slmr_mulmod u_mulmod (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod),
    .mod_o  (mul_mod)
  );

  // Slot = floor(last * N / (2^31 - 2 + N)). Dividing by 2^31 instead gives
  // a candidate that is at most one too large; it is too large exactly when
  // cand * (N - 2) exceeds the low 31 bits of last * N.
  assign slot_cand   = mul_prod[ValueW +: IdxW];
  assign slot_excess = {{IdxW{1'b0}}, slot_cand} * {{IdxW{1'b0}}, SlotCorr};
  assign slot_raw    = ({{(ValueW - 2*IdxW){1'b0}}, slot_excess} > mul_prod[ValueW-1:0])
                     ? slot_cand - IdxW'(1) : slot_cand;
  assign slot_d      = (slot_raw > IdxMax) ? IdxMax : slot_raw;

  // Table writes come from the warm-up fill and from the swap of a draw.
  assign ram_we    = ((state_q == S_SFOLD) && (cnt_q < CntTable))
                  || ((state_q == S_READ) && out_free);
  assign ram_waddr = (state_q == S_READ) ? slot_q : cnt_q[IdxW-1:0];
  assign ram_wdata = (state_q == S_READ) ? lehmer_q : mul_mod;
  assign ram_re    = (state_q == S_SLOT);

  slmr_ram #(
    .Width (ValueW),
    .Depth (TableSize)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_d),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lehmer_d    = lehmer_q;
    last_d      = last_q;
    out_value_d = out_value_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if ((req_i.operation == OpSeed) || (last_q == '0)) begin
            lehmer_d = seed_fixed;
            cnt_d    = CntLast;
            state_d  = S_SMUL;
          end else begin
            state_d = S_DMUL;
          end
        end
      end
      S_SMUL: begin
        state_d = S_SFOLD;
      end
      S_SFOLD: begin
        // The table fills from the top slot down; slot 0 seeds last_q.
        lehmer_d = mul_mod;
        if (cnt_q == '0) begin
          last_d  = mul_mod;
          state_d = S_DMUL;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_SMUL;
        end
      end
      S_DMUL: begin
        state_d = S_DFOLD;
      end
      S_DFOLD: begin
        lehmer_d = mul_mod;
        state_d  = S_SLOT;
      end
      S_SLOT: begin
        state_d = S_READ;
      end
      S_READ: begin
        // The picked entry leaves, the new state takes its slot.
        if (out_free) begin
          last_d      = ram_rdata;
          out_value_d = ram_rdata;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lehmer_q    <= ValueW'(1);
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lehmer_q    <= lehmer_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    if (state_q == S_SLOT) begin
      slot_q <= slot_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.random_value = out_value_q;

  // A new result appears only at the end of the table swap.
  `SLMR_ASSERT(a_result_from_swap, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_READ))
  // The generator state never locks at zero or leaves the residue range.
  `SLMR_ASSERT_NEVER(a_state_range, clk_i, rst_ni, (lehmer_q == '0) || (lehmer_q == LehmerMod))
  // A draw always works from a seeded table and picks a slot inside it.
  `SLMR_ASSERT(a_slot_seeded, clk_i, rst_ni, (state_q == S_SLOT) |-> ((last_q != '0) && (slot_d <= IdxMax)))

endmodule

// ----- rtl/slmr_ram.sv -----
// Generic single write port RAM with one registered read port.
module slmr_ram
  import slmr_pkg::*;
#(
  parameter int unsigned Width = ValueW,
  parameter int unsigned Depth = TableSizeDefault,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/slmr_mulmod.sv -----
// Shared multiplier with registered product and a fold modulo 2^31-1.
module slmr_mulmod
  import slmr_pkg::*;
(
  input  logic              clk_i,
  input  mul_req_t          req_i,
  output logic [ProdW-1:0]  prod_o,
  output logic [ValueW-1:0] mod_o
);

  logic [ProdW-1:0]  prod_d;
  logic [ProdW-1:0]  prod_q;
  logic [ValueW:0]   fold_sum;
  logic [ValueW:0]   fold_sub;

  assign prod_d = {{MulW{1'b0}}, req_i.a} * {{ValueW{1'b0}}, req_i.b};

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      prod_q <= prod_d;
    end
  end

  // Since 2^31 is congruent to 1, the high part adds onto the low part.
  // One conditional subtract finishes the reduction for products of a
  // residue by the 15 bit multiplier.
  assign fold_sum = {1'b0, prod_q[ValueW-1:0]}
                  + {{(ValueW + 1 - MulW){1'b0}}, prod_q[ProdW-1:ValueW]};
  assign fold_sub = fold_sum - {1'b0, LehmerMod};

  assign mod_o  = (fold_sum >= {1'b0, LehmerMod}) ? fold_sub[ValueW-1:0]
                                                  : fold_sum[ValueW-1:0];
  assign prod_o = prod_q;

endmodule
